// ===== sv/rmc_pkg.sv =====
// rmc_pkg: shared types, operation codes and register indexes for the
// repeat-offset move-to-front cache. No dependencies.
`timescale 1ns / 1ps
package rmc_pkg;

	// sizes fixed by the external fields
	localparam int FIELD_BITS   = 16;
	localparam int FUNC_BITS    = 3;
	localparam int POS_BITS     = 2;
	localparam int NUM_ENTRIES  = 4;
	localparam int CFG_IDX_BITS = 3;
	localparam int WIDE_BITS    = 32;
	localparam int OFS_BITS_DEF = 16;

	// recency order after reinit: position p holds entry p
	localparam logic [7:0] ORDER_IDENTITY = 8'he4;

	// operation codes
	localparam logic [FUNC_BITS-1:0] FN_MTF     = 3'd0;
	localparam logic [FUNC_BITS-1:0] FN_ADD     = 3'd1;
	localparam logic [FUNC_BITS-1:0] FN_READ    = 3'd2;
	localparam logic [FUNC_BITS-1:0] FN_FIND    = 3'd3;
	localparam logic [FUNC_BITS-1:0] FN_SAVE    = 3'd4;
	localparam logic [FUNC_BITS-1:0] FN_RESTORE = 3'd5;
	localparam logic [FUNC_BITS-1:0] FN_REINIT  = 3'd6;

	// configuration register indexes
	localparam logic [CFG_IDX_BITS-1:0] CFG_INIT_A  = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_INIT_B  = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_INIT_C  = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_INIT_D  = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] CFG_SL_MODE = 3'd4;

	// position -> entry map, one 2-bit field per position
	typedef logic [NUM_ENTRIES-1:0][POS_BITS-1:0] order_t;

	typedef struct packed {
		logic [FUNC_BITS-1:0]  func;
		logic [POS_BITS-1:0]   position;
		logic [FIELD_BITS-1:0] offset_value;
	} req_t;

	typedef struct packed {
		logic [POS_BITS-1:0]   found_position;
		logic                  found;
		logic [FIELD_BITS-1:0] read_offset;
	} result_t;

	typedef struct packed {
		logic [NUM_ENTRIES-1:0][FIELD_BITS-1:0] init_offset;
		logic                                   sl_mode;
	} cfg_t;

endpackage

// ===== sv/rmc_cfg.sv =====
// rmc_cfg: configuration register bank (initial offsets, second-last mode).
// Depends on rmc_pkg.
`timescale 1ns / 1ps
module rmc_cfg
	import rmc_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    wr_en,
	input  logic [CFG_IDX_BITS-1:0] wr_index,
	input  logic [FIELD_BITS-1:0]   wr_data,
	output cfg_t                    cfg
);

	cfg_t cfg_q;

	// register writes, unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_INIT_A:  cfg_q.init_offset[0] <= wr_data;
				CFG_INIT_B:  cfg_q.init_offset[1] <= wr_data;
				CFG_INIT_C:  cfg_q.init_offset[2] <= wr_data;
				CFG_INIT_D:  cfg_q.init_offset[3] <= wr_data;
				CFG_SL_MODE: cfg_q.sl_mode        <= wr_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== sv/rmc_store.sv =====
// rmc_store: offset entries, recency order, snapshot and the per-request
// lookup / update logic. Depends on rmc_pkg.
`timescale 1ns / 1ps
module rmc_store
	import rmc_pkg::*;
#(
	parameter int OFFSET_BITS = OFS_BITS_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    en,
	input  req_t    req,
	input  cfg_t    cfg,
	output result_t res
);

	logic [NUM_ENTRIES-1:0][OFFSET_BITS-1:0] entry_q, entry_d, saved_entry_q;
	logic [NUM_ENTRIES-1:0][OFFSET_BITS-1:0] init_entry;
	order_t                                  order_q, order_d, saved_order_q, mtf_order;
	logic [WIDE_BITS-1:0]                    val_wide, rd_wide;
	logic [OFFSET_BITS-1:0]                  val;
	logic                                    hit;
	logic [POS_BITS-1:0]                     hit_pos;
	logic [POS_BITS-1:0]                     last_idx, sec_idx;

	// request offset brought to the stored width
	assign val_wide = WIDE_BITS'(req.offset_value);
	assign val      = val_wide[OFFSET_BITS-1:0];

	// offset at the requested position, before any update
	assign rd_wide         = WIDE_BITS'(entry_q[order_q[req.position]]);
	assign res.read_offset = rd_wide[FIELD_BITS-1:0];

	// configured offsets at the stored width
	always_comb begin
		logic [WIDE_BITS-1:0] w;
		w = '0;
		for (int i = 0; i < NUM_ENTRIES; i++) begin
			w             = WIDE_BITS'(cfg.init_offset[i]);
			init_entry[i] = w[OFFSET_BITS-1:0];
		end
	end

	// four-way compare, lowest matching position wins
	always_comb begin
		hit     = 1'b0;
		hit_pos = '0;
		for (int p = NUM_ENTRIES - 1; p >= 0; p--) begin
			if (entry_q[order_q[p]] == val) begin
				hit     = 1'b1;
				hit_pos = POS_BITS'(p);
			end
		end
	end

	assign res.found          = (req.func == FN_FIND) && hit;
	assign res.found_position = (req.func == FN_FIND) ? hit_pos : '0;

	// move to front: chosen entry to position 0, those ahead slide back one
	always_comb begin
		for (int p = 0; p < NUM_ENTRIES; p++) begin
			if (p == 0)
				mtf_order[p] = order_q[req.position];
			else if (POS_BITS'(p) <= req.position)
				mtf_order[p] = order_q[p-1];
			else
				mtf_order[p] = order_q[p];
		end
	end

	assign last_idx = order_q[NUM_ENTRIES-1];
	assign sec_idx  = order_q[NUM_ENTRIES-2];

	// next state per operation
	always_comb begin
		entry_d = entry_q;
		order_d = order_q;
		unique case (req.func)
			FN_MTF: order_d = mtf_order;
			FN_ADD: begin
				if (cfg.sl_mode) begin
					entry_d[last_idx] = entry_q[sec_idx];
					entry_d[sec_idx]  = val;
				end else begin
					entry_d[last_idx] = val;
				end
			end
			FN_RESTORE: begin
				entry_d = saved_entry_q;
				order_d = saved_order_q;
			end
			FN_REINIT: begin
				entry_d = init_entry;
				order_d = ORDER_IDENTITY;
			end
			default: ;
		endcase
	end

	// live state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
			order_q <= ORDER_IDENTITY;
		end else if (en) begin
			entry_q <= entry_d;
			order_q <= order_d;
		end
	end

	// snapshot, meaningful only once saved
	always_ff @(posedge clk) begin
		if (en && (req.func == FN_SAVE)) begin
			saved_entry_q <= entry_q;
			saved_order_q <= order_q;
		end
	end

`ifndef SYNTH
	a_reinit_order: assert property (@(posedge clk) disable iff (!arst_n)
		en && (req.func == FN_REINIT) |=> order_q == ORDER_IDENTITY)
		else $error("reinit did not restore identity order");

	a_add_keeps_order: assert property (@(posedge clk) disable iff (!arst_n)
		en && (req.func == FN_ADD) |=> $stable(order_q))
		else $error("add new changed the recency order");

	a_mtf_front: assert property (@(posedge clk) disable iff (!arst_n)
		en && (req.func == FN_MTF) |=> order_q[0] == $past(order_q[req.position]))
		else $error("move to front put the wrong entry at the front");
`endif

endmodule

// ===== sv/repeat_offset_mtf_cache.sv =====
// repeat_offset_mtf_cache: top level, request register, result register and
// handshakes. Depends on rmc_pkg, rmc_cfg and rmc_store.
//
// channel   dir  signals                              request
// s_*       in   s_tvalid s_tready s_tdata s_tuser    one operation
// m_*       out  m_tvalid m_tready m_tdata            one result per operation
// cfg_*     in   cfg_valid cfg_ready cfg_index cfg_data  register write
//
// One request per cycle sustained while m_tready is high; each result
// passes the request register, then the result register, on its way out.
// The store is read and updated in the cycle the request moves from the
// request register into the result register.
// A stalled result holds the result register; one more request waits in
// the request register, after which s_tready drops.
// arst_n clears the pipeline, the registers and the entries (order identity).
`timescale 1ns / 1ps
module repeat_offset_mtf_cache
	import rmc_pkg::*;
#(
	parameter int OFFSET_BITS = OFS_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_tvalid,
	output logic                    s_tready,
	input  logic [23:0]             s_tdata,   // [1:0] position, [17:2] offset_value, zero fill
	input  logic [FUNC_BITS-1:0]    s_tuser,   // [2:0] func
	output logic                    m_tvalid,
	input  logic                    m_tready,
	output logic [23:0]             m_tdata,   // [15:0] read_offset, [16] found,
	                                           // [18:17] found_position, zero fill
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [FIELD_BITS-1:0]   cfg_data
);

	cfg_t    cfg;
	req_t    req_s1;
	logic    valid_s1;
	result_t res, res_s2;
	logic    valid_s2;
	logic    advance;
	logic    in_take;

	assign cfg_ready = 1'b1;

	rmc_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// request moves on when the result register is free or being emptied
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign in_take  = s_tvalid && s_tready;

	// request register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			req_s1.func         <= s_tuser;
			req_s1.position     <= s_tdata[POS_BITS-1:0];
			req_s1.offset_value <= s_tdata[POS_BITS+FIELD_BITS-1:POS_BITS];
		end
	end

	rmc_store #(
		.OFFSET_BITS (OFFSET_BITS)
	) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.req    (req_s1),
		.cfg    (cfg),
		.res    (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {5'b0, res_s2.found_position, res_s2.found, res_s2.read_offset};

`ifndef SYNTH
	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> valid_s1 && valid_s2 && !m_tready)
		else $error("input stalled while the pipeline had room");

	a_advance_fills: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2)
		else $error("result register empty after a request moved on");
`endif

endmodule
